>>> hw/rtl/smk_pkg.sv
`default_nettype none
package smk_pkg;

    localparam int DATA_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int ORDER_W = 4;

    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLE_ORDER    = 3'd0,
        CFG_KICK_STRENGTH = 3'd1,
        CFG_TILT_COS      = 3'd2,
        CFG_TILT_SIN      = 3'd3,
        CFG_OFFSET_X      = 3'd4,
        CFG_OFFSET_Y      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] mom_x;
        logic signed [DATA_W-1:0] mom_y;
        logic signed [DATA_W-1:0] mom_dev;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_mom_x;
        logic signed [DATA_W-1:0] new_mom_y;
        logic                     range_fault;
    } t_out;

    typedef struct packed {
        logic                     flt;
        logic signed [DATA_W-1:0] val;
    } t_sat;

    typedef struct packed {
        logic                     vld;
        logic                     act;
        logic                     flt;
        logic                     ovx;
        logic                     ovy;
        logic                     sgx;
        logic                     sgy;
        logic signed [DATA_W-1:0] mx;
        logic signed [DATA_W-1:0] my;
        logic signed [DATA_W-1:0] d;
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] cr;
        logic signed [DATA_W-1:0] ci;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] tx;
        logic signed [DATA_W-1:0] ty;
        logic [DATA_W-1:0]        rx;
        logic [DATA_W-1:0]        ry;
        logic [DATA_W-1:0]        nx;
        logic [DATA_W-1:0]        ny;
        logic [DATA_W-1:0]        qx;
        logic [DATA_W-1:0]        qy;
    } t_beat;

    function automatic t_sat sat_add(logic signed [DATA_W-1:0] a,
                                     logic signed [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        t_sat r;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        r.flt = s[DATA_W] ^ s[DATA_W-1];
        r.val = r.flt ? (s[DATA_W] ? SMIN : SMAX) : s[DATA_W-1:0];
        return r;
    endfunction

    function automatic t_sat sat_sub(logic signed [DATA_W-1:0] a,
                                     logic signed [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        t_sat r;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        r.flt = s[DATA_W] ^ s[DATA_W-1];
        r.val = r.flt ? (s[DATA_W] ? SMIN : SMAX) : s[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] mag(logic signed [DATA_W-1:0] a);
        return a[DATA_W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic t_sat from_mag(logic [DATA_W-1:0] m, logic neg);
        t_sat r;
        r.flt = 1'b0;
        if (!neg) begin
            r.flt = m[DATA_W-1];
            r.val = r.flt ? SMAX : m;
        end else if (m[DATA_W-1] && (m[DATA_W-2:0] != '0)) begin
            r.flt = 1'b1;
            r.val = SMIN;
        end else begin
            r.val = ~m + 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/smk_qmul.sv
`default_nettype none
module smk_qmul #(
    parameter int FRAC_BITS = 48
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [smk_pkg::DATA_W-1:0]  i_a,
    input  wire logic signed [smk_pkg::DATA_W-1:0]  i_b,
    output logic signed [smk_pkg::DATA_W-1:0]       o_p,
    output logic                                    o_flt
);
    localparam int W = smk_pkg::DATA_W;
    localparam int H = W / 2;

    logic [W-1:0]   ma, mb;
    logic           r_neg;
    logic [W-1:0]   r_p0, r_p1, r_p2, r_p3;
    logic [2*W-1:0] sum, shf;
    smk_pkg::t_sat  fm;

    assign ma = smk_pkg::mag(i_a);
    assign mb = smk_pkg::mag(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_a[W-1] ^ i_b[W-1];
            r_p0  <= ma[H-1:0] * mb[H-1:0];
            r_p1  <= ma[H-1:0] * mb[W-1:H];
            r_p2  <= ma[W-1:H] * mb[H-1:0];
            r_p3  <= ma[W-1:H] * mb[W-1:H];
        end
    end

    always_comb begin
        sum = {{W{1'b0}}, r_p0} + ({{W{1'b0}}, r_p1} << H) + ({{W{1'b0}}, r_p2} << H)
            + {r_p3, {W{1'b0}}} + ({{(2*W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));
        shf = sum >> FRAC_BITS;
        fm  = smk_pkg::from_mag(shf[W-1:0], r_neg);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (shf[2*W-1:W] != '0) begin
                o_flt <= 1'b1;
                o_p   <= r_neg ? smk_pkg::SMIN : smk_pkg::SMAX;
            end else begin
                o_flt <= fm.flt;
                o_p   <= fm.val;
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/smk_pow_cell.sv
`default_nettype none
module smk_pow_cell #(
    parameter int K = 0,
    parameter int FRAC_BITS = 48
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic [smk_pkg::ORDER_W-1:0]         i_order,
    input  wire smk_pkg::t_beat                      i_beat,
    output smk_pkg::t_beat                           o_beat
);
    localparam logic [smk_pkg::ORDER_W-1:0] KV = smk_pkg::ORDER_W'(K);

    logic signed [smk_pkg::DATA_W-1:0] q0, q1, q2, q3;
    logic f0, f1, f2, f3;
    smk_pkg::t_beat r_d1, r_d2, n_o;
    smk_pkg::t_sat  nr, ni;

    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_m0 (.i_clk, .i_en, .i_a(i_beat.cr), .i_b(i_beat.u),
                                            .o_p(q0), .o_flt(f0));
    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.i_clk, .i_en, .i_a(i_beat.ci), .i_b(i_beat.v),
                                            .o_p(q1), .o_flt(f1));
    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_m2 (.i_clk, .i_en, .i_a(i_beat.cr), .i_b(i_beat.v),
                                            .o_p(q2), .o_flt(f2));
    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_m3 (.i_clk, .i_en, .i_a(i_beat.ci), .i_b(i_beat.u),
                                            .o_p(q3), .o_flt(f3));

    always_comb begin
        nr  = smk_pkg::sat_sub(q0, q1);
        ni  = smk_pkg::sat_add(q2, q3);
        n_o = r_d2;
        if (KV < i_order) begin
            n_o.cr  = nr.val;
            n_o.ci  = ni.val;
            n_o.flt = r_d2.flt | f0 | f1 | f2 | f3 | nr.flt | ni.flt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1.vld   <= 1'b0;
            r_d2.vld   <= 1'b0;
            o_beat.vld <= 1'b0;
        end else if (i_en) begin
            r_d1   <= i_beat;
            r_d2   <= r_d1;
            o_beat <= n_o;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/smk_kick.sv
`default_nettype none
module smk_kick #(
    parameter int FRAC_BITS = 48
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire smk_pkg::t_beat  i_beat,
    output smk_pkg::t_beat       o_beat
);
    logic signed [smk_pkg::DATA_W-1:0] q0, q1, q2, q3;
    logic f0, f1, f2, f3;
    smk_pkg::t_beat r_d1, r_d2, n_o;
    smk_pkg::t_sat  kx, ky;

    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_m0 (.i_clk, .i_en, .i_a(i_beat.a), .i_b(i_beat.ci),
                                            .o_p(q0), .o_flt(f0));
    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.i_clk, .i_en, .i_a(i_beat.b), .i_b(i_beat.cr),
                                            .o_p(q1), .o_flt(f1));
    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_m2 (.i_clk, .i_en, .i_a(i_beat.a), .i_b(i_beat.cr),
                                            .o_p(q2), .o_flt(f2));
    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_m3 (.i_clk, .i_en, .i_a(i_beat.b), .i_b(i_beat.ci),
                                            .o_p(q3), .o_flt(f3));

    always_comb begin
        kx      = smk_pkg::sat_sub(q0, q1);
        ky      = smk_pkg::sat_sub(q2, q3);
        n_o     = r_d2;
        n_o.tx  = kx.val;
        n_o.ty  = ky.val;
        n_o.flt = r_d2.flt | f0 | f1 | f2 | f3 | kx.flt | ky.flt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1.vld   <= 1'b0;
            r_d2.vld   <= 1'b0;
            o_beat.vld <= 1'b0;
        end else if (i_en) begin
            r_d1   <= i_beat;
            r_d2   <= r_d1;
            o_beat <= n_o;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/smk_div_cell.sv
`default_nettype none
module smk_div_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire smk_pkg::t_beat  i_beat,
    output smk_pkg::t_beat       o_beat
);
    localparam int W = smk_pkg::DATA_W;

    logic [W:0] dd, rx, ry, sx, sy;
    logic       gx, gy;
    smk_pkg::t_beat n_o;

    always_comb begin
        dd  = {1'b0, i_beat.d};
        rx  = {i_beat.rx, i_beat.nx[W-1]};
        ry  = {i_beat.ry, i_beat.ny[W-1]};
        sx  = rx - dd;
        sy  = ry - dd;
        gx  = rx >= dd;
        gy  = ry >= dd;
        n_o = i_beat;
        n_o.rx = gx ? sx[W-1:0] : rx[W-1:0];
        n_o.ry = gy ? sy[W-1:0] : ry[W-1:0];
        n_o.nx = i_beat.nx << 1;
        n_o.ny = i_beat.ny << 1;
        n_o.qx = {i_beat.qx[W-2:0], gx};
        n_o.qy = {i_beat.qy[W-2:0], gy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_beat.vld <= 1'b0;
        end else if (i_en) begin
            o_beat <= n_o;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/skew_multipole_thin_kick_top.sv
`default_nettype none
// Thin-lens skew multipole kick, one particle per beat, fully pipelined.
// The input channel takes one particle per beat (position, momentum and
// momentum deviation); the output channel returns the kicked momenta and
// a fault flag that is set on any saturation or when 1+deviation is not
// positive. Both channels use valid and ready.
// A new particle is taken in every cycle while the pipeline is not
// stalled (see below). Each beat passes one front stage, the rotation
// multiplies, one complex multiply cell per possible power, the kick
// multiplies, and a 64-cell restoring divider with one quotient bit per
// cell, followed by the output register.
// Cells beyond the programmed order pass the beat through unchanged, so the
// latency does not depend on the order.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps filling until a finished beat reaches its last stage; only
// then does the input stop taking beats.
// Reset: order 0, strength 0, cosine 1.0, sine 0, offsets 0, pipeline empty.
// The user writes registers only when idle; the block does not enforce it.
module skew_multipole_thin_kick_top #(
    parameter int MAX_ORDER = 8,
    parameter int FRAC_BITS = 48
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire smk_pkg::t_in                          i_in_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output smk_pkg::t_out                              o_out_data,
    input  wire logic                                  i_cfg_we,
    input  wire logic [smk_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [smk_pkg::DATA_W-1:0]            i_cfg_data
);
    localparam int W = smk_pkg::DATA_W;
    localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;
    localparam logic [smk_pkg::ORDER_W-1:0] MAXO = smk_pkg::ORDER_W'(MAX_ORDER);

    logic [smk_pkg::ORDER_W-1:0] r_order, eff_order;
    logic signed [W-1:0] r_ks, r_cos, r_sin, r_offx, r_offy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= '0;
            r_ks    <= '0;
            r_cos   <= ONE;
            r_sin   <= '0;
            r_offx  <= '0;
            r_offy  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smk_pkg::CFG_POLE_ORDER:    r_order <= i_cfg_data[smk_pkg::ORDER_W-1:0];
                smk_pkg::CFG_KICK_STRENGTH: r_ks    <= i_cfg_data;
                smk_pkg::CFG_TILT_COS:      r_cos   <= i_cfg_data;
                smk_pkg::CFG_TILT_SIN:      r_sin   <= i_cfg_data;
                smk_pkg::CFG_OFFSET_X:      r_offx  <= i_cfg_data;
                smk_pkg::CFG_OFFSET_Y:      r_offy  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_order = (r_order > MAXO) ? MAXO : r_order;

    logic en;
    smk_pkg::t_beat r_a, n_a, r_b1, r_b2, r_c, n_c, r_v, n_v, s_last, n_fin;
    smk_pkg::t_beat s_pow [MAX_ORDER+1];
    smk_pkg::t_beat s_kick;
    smk_pkg::t_beat s_div [W+1];
    smk_pkg::t_sat  dsum, dxs, dys;

    // Front stage: momentum divisor and entry displacement.
    always_comb begin
        dsum    = smk_pkg::sat_add(i_in_data.mom_dev, ONE);
        dxs     = smk_pkg::sat_sub(i_in_data.pos_x, r_offx);
        dys     = smk_pkg::sat_sub(i_in_data.pos_y, r_offy);
        n_a     = '0;
        n_a.vld = i_in_valid;
        n_a.act = !dsum.val[W-1] && (dsum.val != '0);
        n_a.flt = dsum.flt | dxs.flt | dys.flt;
        n_a.mx  = i_in_data.mom_x;
        n_a.my  = i_in_data.mom_y;
        n_a.d   = dsum.val;
        n_a.u   = dxs.val;
        n_a.v   = dys.val;
    end

    logic signed [W-1:0] q0, q1, q2, q3, q4, q5;
    logic f0, f1, f2, f3, f4, f5;
    smk_pkg::t_sat us, vs;

    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_r0 (.i_clk, .i_en(en), .i_a(r_a.u), .i_b(r_cos),
                                            .o_p(q0), .o_flt(f0));
    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_r1 (.i_clk, .i_en(en), .i_a(r_a.v), .i_b(r_sin),
                                            .o_p(q1), .o_flt(f1));
    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_r2 (.i_clk, .i_en(en), .i_a(r_a.v), .i_b(r_cos),
                                            .o_p(q2), .o_flt(f2));
    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_r3 (.i_clk, .i_en(en), .i_a(r_a.u), .i_b(r_sin),
                                            .o_p(q3), .o_flt(f3));
    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_r4 (.i_clk, .i_en(en), .i_a(r_ks), .i_b(r_cos),
                                            .o_p(q4), .o_flt(f4));
    smk_qmul #(.FRAC_BITS(FRAC_BITS)) u_r5 (.i_clk, .i_en(en), .i_a(r_ks), .i_b(r_sin),
                                            .o_p(q5), .o_flt(f5));

    always_comb begin
        us      = smk_pkg::sat_add(q0, q1);
        vs      = smk_pkg::sat_sub(q2, q3);
        n_c     = r_b2;
        n_c.u   = us.val;
        n_c.v   = vs.val;
        n_c.cr  = us.val;
        n_c.ci  = vs.val;
        n_c.a   = q4;
        n_c.b   = q5;
        n_c.flt = r_b2.flt | f0 | f1 | f2 | f3 | f4 | f5 | us.flt | vs.flt;
    end

    assign s_pow[0] = r_c;

    for (genvar k = 0; k < MAX_ORDER; k++) begin : g_pow
        smk_pow_cell #(.K(k), .FRAC_BITS(FRAC_BITS)) u_cell (
            .i_clk, .i_rst_n, .i_en(en), .i_order(eff_order),
            .i_beat(s_pow[k]), .o_beat(s_pow[k+1])
        );
    end

    smk_kick #(.FRAC_BITS(FRAC_BITS)) u_kick (
        .i_clk, .i_rst_n, .i_en(en), .i_beat(s_pow[MAX_ORDER]), .o_beat(s_kick)
    );

    // Divider setup: the high quotient word is nonzero exactly when the
    // top bits of the shifted numerator already reach the divisor.
    logic [W-1:0] mgx, mgy, nhx, nhy;
    always_comb begin
        mgx     = smk_pkg::mag(s_kick.tx);
        mgy     = smk_pkg::mag(s_kick.ty);
        nhx     = mgx >> (W - FRAC_BITS);
        nhy     = mgy >> (W - FRAC_BITS);
        n_v     = s_kick;
        n_v.sgx = s_kick.tx[W-1];
        n_v.sgy = s_kick.ty[W-1];
        n_v.ovx = nhx >= W'(s_kick.d);
        n_v.ovy = nhy >= W'(s_kick.d);
        n_v.rx  = nhx;
        n_v.ry  = nhy;
        n_v.nx  = mgx << FRAC_BITS;
        n_v.ny  = mgy << FRAC_BITS;
        n_v.qx  = '0;
        n_v.qy  = '0;
    end

    assign s_div[0] = r_v;

    for (genvar j = 0; j < W; j++) begin : g_div
        smk_div_cell u_cell (
            .i_clk, .i_rst_n, .i_en(en), .i_beat(s_div[j]), .o_beat(s_div[j+1])
        );
    end

    assign s_last = s_div[W];

    smk_pkg::t_sat qxs, qys, pxs, pys;
    logic          fqx, fqy;
    logic signed [W-1:0] kqx, kqy;
    always_comb begin
        qxs = smk_pkg::from_mag(s_last.qx, s_last.sgx);
        qys = smk_pkg::from_mag(s_last.qy, s_last.sgy);
        kqx = s_last.ovx ? (s_last.sgx ? smk_pkg::SMIN : smk_pkg::SMAX) : qxs.val;
        kqy = s_last.ovy ? (s_last.sgy ? smk_pkg::SMIN : smk_pkg::SMAX) : qys.val;
        fqx = s_last.ovx | qxs.flt;
        fqy = s_last.ovy | qys.flt;
        pxs = smk_pkg::sat_add(s_last.mx, kqx);
        pys = smk_pkg::sat_add(s_last.my, kqy);
        n_fin = s_last;
        if (s_last.act) begin
            n_fin.mx  = pxs.val;
            n_fin.my  = pys.val;
            n_fin.flt = s_last.flt | fqx | fqy | pxs.flt | pys.flt;
        end else begin
            n_fin.flt = 1'b1;
        end
    end

    assign en         = !s_last.vld || !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld  <= 1'b0;
            r_b1.vld <= 1'b0;
            r_b2.vld <= 1'b0;
            r_c.vld  <= 1'b0;
            r_v.vld  <= 1'b0;
        end else if (en) begin
            r_a  <= n_a;
            r_b1 <= r_a;
            r_b2 <= r_b1;
            r_c  <= n_c;
            r_v  <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (!o_out_valid || i_out_ready) begin
            o_out_valid            <= s_last.vld;
            o_out_data.new_mom_x   <= n_fin.mx;
            o_out_data.new_mom_y   <= n_fin.my;
            o_out_data.range_fault <= n_fin.flt;
        end
    end
endmodule
`default_nettype wire
